// ----- design/rrmu_pkg.sv -----
// Shared codes and widths for the robust recursive mutex unit.
`default_nettype none

package rrmu_pkg;

    // Item field widths
    localparam int CMD_W    = 3;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 3;
    localparam int HOLD_W   = 8;
    localparam int RSTATE_W = 2;
    localparam int KIND_W   = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [RSTATE_W-1:0] t_rstate;
    typedef logic [KIND_W-1:0]   t_kind;

    // Commands
    localparam t_cmd CMD_TRYLOCK    = 3'd0;
    localparam t_cmd CMD_LOCK       = 3'd1;
    localparam t_cmd CMD_UNLOCK     = 3'd2;
    localparam t_cmd CMD_CONSISTENT = 3'd3;
    localparam t_cmd CMD_DESTROY    = 3'd4;
    localparam t_cmd CMD_INIT       = 3'd5;

    // Status codes
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_INVALID   = 3'd1;
    localparam t_status ST_DEADLOCK  = 3'd2;
    localparam t_status ST_BUSY      = 3'd3;
    localparam t_status ST_OWNERDEAD = 3'd4;
    localparam t_status ST_PERM      = 3'd5;
    localparam t_status ST_RETRY     = 3'd6;

    // Robust states
    localparam t_rstate RS_NORMAL       = 2'd0;
    localparam t_rstate RS_INCONSISTENT = 2'd1;
    localparam t_rstate RS_UNUSABLE     = 2'd2;

    // Mutex kinds (code 3 acts as normal)
    localparam t_kind KIND_NORMAL    = 2'd0;
    localparam t_kind KIND_RECURSIVE = 2'd1;
    localparam t_kind KIND_ERRCHECK  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_KIND   = 1'b0;
    localparam logic CFG_ROBUST = 1'b1;

endpackage

`default_nettype wire

// ----- design/robust_recursive_mutex_unit.sv -----
// Top level of the robust recursive mutex unit: one hardware mutex driven by a command stream.
`default_nettype none

// One mutex, one command item in, one result item out. An accepted item sits
// in an input register until the result register is free or draining; then
// the command logic reads the mutex state (count, owner, owner-recorded flag,
// robust state), updates it and loads the result register. While the output
// is not stalled the unit sustains one item per cycle: the state is read,
// modified and written back between the input and result registers, so
// back-to-back items see each other's updates. The result register parts the
// two sides: a stalled output holds the command stage, and the input stays
// ready while the input register is empty or about to move on. Lock never
// sleeps: a mutex that cannot be taken answers busy/wait. Recursive counts
// saturate at all ones and then answer retry. In robust mode a lock against a
// recorded but dead owner takes the mutex over, answers owner dead and marks
// the mutex inconsistent. Configuration (kind, robust mode) is written on the
// plain write port; the user must write it only while the unit is idle, which
// the block does not enforce. There is no read-back.
module robust_recursive_mutex_unit
    import rrmu_pkg::*;
#(
    parameter int THREAD_ID_BITS = 8,
    parameter int COUNT_BITS     = 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // command items
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [2:0] command, [10:3] caller_id, [11] owner_alive, [15:12] zero
    input  wire [IN_TDATA_W-1:0]   i_s_axis_tdata,
    // result items
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    // [2:0] status, [3] acquire_event, [4] release_event, [12:5] hold_count,
    // [15:13] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // configuration writes
    input  wire                    i_cfg_wen,
    input  wire                    i_cfg_idx,
    input  wire [KIND_W-1:0]       i_cfg_wdata
);

    // widths used to move between port fields and internal state
    localparam int ID_EXT_W  = (THREAD_ID_BITS > ID_W) ? THREAD_ID_BITS : ID_W;
    localparam int CNT_EXT_W = (COUNT_BITS > HOLD_W) ? COUNT_BITS : HOLD_W;
    localparam int PAD_W     = OUT_TDATA_W - STATUS_W - 2 - HOLD_W;

    // configuration
    t_kind r_kind;
    logic  r_robust;

    // mutex state
    logic [COUNT_BITS-1:0]     r_lock_count, n_lock_count;
    logic [THREAD_ID_BITS-1:0] r_owner_id,   n_owner_id;
    logic                      r_owner_rec,  n_owner_rec;
    t_rstate                   r_rstate,     n_rstate;

    // input stage
    logic            r_in_valid;
    t_cmd            r_cmd;
    logic [ID_W-1:0] r_caller;
    logic            r_alive;

    // result stage
    logic              r_out_valid;
    t_status           r_status,  n_status;
    logic              r_acq,     n_acq;
    logic              r_rel,     n_rel;
    logic [HOLD_W-1:0] r_hold;

    logic                      w_advance;
    logic                      w_fire;
    logic [ID_EXT_W-1:0]       w_caller_ext;
    logic [THREAD_ID_BITS-1:0] w_who;
    logic                      w_is_owner;
    logic                      w_cnt_zero;
    logic                      w_cnt_full;
    logic [CNT_EXT_W-1:0]      w_cnt_ext;

    // result register free or draining this cycle
    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && w_advance;
    assign o_s_axis_tready = !r_in_valid || w_advance;

    assign w_caller_ext = ID_EXT_W'(r_caller);
    assign w_who        = w_caller_ext[THREAD_ID_BITS-1:0];
    assign w_is_owner   = r_owner_rec && (r_owner_id == w_who);
    assign w_cnt_zero   = (r_lock_count == '0);
    assign w_cnt_full   = &r_lock_count;

    // command logic
    always_comb begin
        n_lock_count = r_lock_count;
        n_owner_id   = r_owner_id;
        n_owner_rec  = r_owner_rec;
        n_rstate     = r_rstate;
        n_status     = ST_OK;
        n_acq        = 1'b0;
        n_rel        = 1'b0;

        unique case (r_cmd) inside
            CMD_TRYLOCK, CMD_LOCK: begin
                if (r_rstate == RS_UNUSABLE) begin
                    n_status = ST_INVALID;
                end else if (w_cnt_zero) begin
                    n_lock_count = COUNT_BITS'(1);
                    n_owner_id   = w_who;
                    n_owner_rec  = 1'b1;
                    n_acq        = 1'b1;
                end else if (r_kind == KIND_RECURSIVE && w_is_owner) begin
                    if (w_cnt_full) begin
                        n_status = ST_RETRY;
                    end else begin
                        n_lock_count = r_lock_count + COUNT_BITS'(1);
                    end
                end else if (r_kind == KIND_ERRCHECK && w_is_owner) begin
                    n_status = ST_DEADLOCK;
                end else if (r_cmd == CMD_LOCK && r_robust && r_owner_rec && !r_alive) begin
                    // robust takeover from a dead owner
                    n_rstate     = RS_INCONSISTENT;
                    n_lock_count = COUNT_BITS'(1);
                    n_owner_id   = w_who;
                    n_owner_rec  = 1'b1;
                    n_acq        = 1'b1;
                    n_status     = ST_OWNERDEAD;
                end else begin
                    n_status = ST_BUSY;
                end
            end
            CMD_UNLOCK: begin
                if (w_cnt_zero || !w_is_owner) begin
                    n_status = ST_PERM;
                end else begin
                    if (r_rstate == RS_INCONSISTENT) begin
                        n_rstate = RS_UNUSABLE;
                    end
                    if (r_kind == KIND_RECURSIVE) begin
                        n_lock_count = r_lock_count - COUNT_BITS'(1);
                        n_rel        = (r_lock_count == COUNT_BITS'(1));
                    end else begin
                        n_lock_count = '0;
                        n_rel        = 1'b1;
                    end
                end
            end
            CMD_CONSISTENT: begin
                if (w_is_owner && r_rstate == RS_INCONSISTENT) begin
                    n_rstate = RS_NORMAL;
                end else begin
                    n_status = ST_INVALID;
                end
            end
            CMD_DESTROY: begin
                n_status = w_cnt_zero ? ST_OK : ST_BUSY;
            end
            CMD_INIT: begin
                n_lock_count = '0;
                n_owner_id   = '0;
                n_owner_rec  = 1'b0;
                n_rstate     = RS_NORMAL;
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    assign w_cnt_ext = CNT_EXT_W'(n_lock_count);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= KIND_NORMAL;
            r_robust <= 1'b0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_KIND:   r_kind   <= i_cfg_wdata;
                CFG_ROBUST: r_robust <= i_cfg_wdata[0];
                default:    r_robust <= r_robust;
            endcase
        end
    end

    // mutex state, updated as each item leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_count <= '0;
            r_owner_id   <= '0;
            r_owner_rec  <= 1'b0;
            r_rstate     <= RS_NORMAL;
        end else if (w_fire) begin
            r_lock_count <= n_lock_count;
            r_owner_id   <= n_owner_id;
            r_owner_rec  <= n_owner_rec;
            r_rstate     <= n_rstate;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_cmd    <= i_s_axis_tdata[CMD_W-1:0];
            r_caller <= i_s_axis_tdata[CMD_W +: ID_W];
            r_alive  <= i_s_axis_tdata[CMD_W + ID_W];
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= n_status;
            r_acq    <= n_acq;
            r_rel    <= n_rel;
            r_hold   <= w_cnt_ext[HOLD_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {PAD_W'(0), r_hold, r_rel, r_acq, r_status};

endmodule

`default_nettype wire

// ----- dv/robust_recursive_mutex_unit_test.sv -----
`timescale 1ns / 100ps
// Testbench for robust_recursive_mutex_unit: directed and random items against a mutex predictor.
module robust_recursive_mutex_unit_test
    import rrmu_pkg::*;
();

    // Command codes the unit must reject, and the kind code that decodes as normal
    localparam t_cmd  CMD_UNUSED6 = 3'd6;
    localparam t_cmd  CMD_UNUSED7 = 3'd7;
    localparam t_kind KIND_SPARE  = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES   = 4;     // quiet margin once every result is back
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 150;

    // Result item as packed in o_m_axis_tdata[12:0]
    typedef struct packed {
        logic [HOLD_W-1:0] hold;
        logic              rel;
        logic              acq;
        t_status           status;
    } t_mutex_result;

    logic                    i_clk;
    logic                    i_rst_n   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    m_tready  = 1'b0;
    logic                    cfg_wen   = 1'b0;
    logic                    cfg_idx   = CFG_KIND;
    logic [KIND_W-1:0]       cfg_wdata = '0;
    wire                     o_s_axis_tready;
    wire                     o_m_axis_tvalid;
    wire  [OUT_TDATA_W-1:0]  o_m_axis_tdata;

    // Predicted mutex state and its configuration
    t_kind             mx_kind      = KIND_NORMAL;
    logic              mx_robust    = 1'b0;
    logic [HOLD_W-1:0] mx_count     = '0;
    logic [ID_W-1:0]   mx_owner     = '0;
    logic              mx_has_owner = 1'b0;
    t_rstate           mx_rstate    = RS_NORMAL;

    t_mutex_result expected_results[$];
    int            errors       = 0;
    int            idle_cycles  = 0;
    int            tx_gap_pct   = 0;   // chance of a gap before an item
    int            rx_stall_pct = 0;   // chance of a stall after a ready cycle
    int            rx_hold      = 0;

    robust_recursive_mutex_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wen       (cfg_wen),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic held_by(input logic [ID_W-1:0] id);
        return mx_has_owner && (mx_owner == id);
    endfunction

    // Shared by trylock and lock: never sleeps, answers busy instead
    function automatic t_status take_mutex(input logic [ID_W-1:0] id, output logic acq);
        acq = 1'b0;
        if (mx_rstate == RS_UNUSABLE)
            return ST_INVALID;
        if (mx_count == 0) begin
            mx_count     = HOLD_W'(1);
            mx_owner     = id;
            mx_has_owner = 1'b1;
            acq          = 1'b1;
            return ST_OK;
        end
        if (mx_kind == KIND_RECURSIVE && held_by(id)) begin
            if (mx_count == '1)
                return ST_RETRY;    // saturated count is kept
            mx_count++;
            return ST_OK;
        end
        if (mx_kind == KIND_ERRCHECK && held_by(id))
            return ST_DEADLOCK;
        return ST_BUSY;
    endfunction

    function automatic t_mutex_result mutex_step(input t_cmd c, input logic [ID_W-1:0] id,
                                                 input logic alive);
        t_mutex_result r;
        r = '0;
        r.status = ST_OK;
        case (c)
            CMD_TRYLOCK: begin
                r.status = take_mutex(id, r.acq);
            end
            CMD_LOCK: begin
                r.status = take_mutex(id, r.acq);
                // robust takeover from a recorded but dead owner
                if (r.status == ST_BUSY && mx_robust && mx_has_owner && !alive) begin
                    mx_rstate    = RS_INCONSISTENT;
                    mx_count     = HOLD_W'(1);
                    mx_owner     = id;
                    mx_has_owner = 1'b1;
                    r.acq        = 1'b1;
                    r.status     = ST_OWNERDEAD;
                end
            end
            CMD_UNLOCK: begin
                if (mx_count == 0 || !held_by(id)) begin
                    r.status = ST_PERM;
                end else begin
                    if (mx_rstate == RS_INCONSISTENT)
                        mx_rstate = RS_UNUSABLE;
                    if (mx_kind == KIND_RECURSIVE)
                        mx_count--;
                    else
                        mx_count = '0;
                    r.rel = (mx_count == 0);   // owner stays recorded
                end
            end
            CMD_CONSISTENT: begin
                if (held_by(id) && mx_rstate == RS_INCONSISTENT)
                    mx_rstate = RS_NORMAL;
                else
                    r.status = ST_INVALID;
            end
            CMD_DESTROY: begin
                r.status = (mx_count != 0) ? ST_BUSY : ST_OK;
            end
            CMD_INIT: begin
                mx_count     = '0;
                mx_owner     = '0;
                mx_has_owner = 1'b0;
                mx_rstate    = RS_NORMAL;
            end
            default: begin
                r.status = ST_INVALID;
            end
        endcase
        r.hold = mx_count;
        return r;
    endfunction

    // ---------------------------------------------------------------- helpers

    function automatic int pick_gap(input int pct);
        if (pct == 0 || $urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);   // occasional long gap
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40)
            $display("ERROR %0t ns: %s", $time, what);
    endtask

    // Drives one item, leaves tvalid high after acceptance so the next item
    // can follow back to back; the prediction is made at the accepting edge.
    task automatic send_item(input t_cmd c, input logic [ID_W-1:0] id, input logic alive);
        int gap;
        gap = pick_gap(tx_gap_pct);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tdata  <= IN_TDATA_W'({alive, id, c});
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_results.push_back(mutex_step(c, id, alive));
    endtask

    // Sender pauses until every result is back and the unit has gone quiet
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers, one per cycle; only called while the unit is idle
    task automatic configure(input t_kind kind, input logic [KIND_W-1:0] robust_wdata);
        cfg_idx   <= CFG_KIND;
        cfg_wdata <= kind;
        cfg_wen   <= 1'b1;
        @(posedge i_clk);
        mx_kind   = kind;
        cfg_idx   <= CFG_ROBUST;
        cfg_wdata <= robust_wdata;
        @(posedge i_clk);
        mx_robust = robust_wdata[0];
        cfg_wen   <= 1'b0;
    endtask

    // ---------------------------------------------------------------- result side

    task automatic check_result(input logic [OUT_TDATA_W-1:0] d);
        t_mutex_result got;
        t_mutex_result want;
        got = d[$bits(t_mutex_result)-1:0];
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", d));
            return;
        end
        want = expected_results.pop_front();
        if (got.status != want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.acq != want.acq)
            report_mismatch($sformatf("acquire_event %0b, want %0b", got.acq, want.acq));
        if (got.rel != want.rel)
            report_mismatch($sformatf("release_event %0b, want %0b", got.rel, want.rel));
        if (got.hold != want.hold)
            report_mismatch($sformatf("hold_count %0d, want %0d", got.hold, want.hold));
    endtask

    // Check on the handshake, then pick tready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready)
            check_result(o_m_axis_tdata);
        if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            rx_hold  <= pick_gap(rx_stall_pct);
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAIL robust_recursive_mutex_unit");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // Reset configuration: normal kind, robust off
    task automatic test_normal_after_reset();
        send_item(CMD_DESTROY, 8'h00, 1'b1);     // free: ok
        send_item(CMD_UNLOCK, 8'h00, 1'b1);      // unlock while free
        send_item(CMD_CONSISTENT, 8'h00, 1'b1);  // nothing to repair
        send_item(CMD_TRYLOCK, 8'h00, 1'b1);
        send_item(CMD_TRYLOCK, 8'h00, 1'b1);     // owner relock of a normal mutex: busy
        send_item(CMD_LOCK, 8'hFF, 1'b1);
        send_item(CMD_LOCK, 8'hFF, 1'b0);        // dead owner, robust off: still busy
        send_item(CMD_DESTROY, 8'hFF, 1'b1);     // held: busy
        send_item(CMD_UNLOCK, 8'hFF, 1'b1);      // non-owner
        send_item(CMD_UNLOCK, 8'h00, 1'b1);      // full release
        send_item(CMD_UNLOCK, 8'h00, 1'b1);
        send_item(CMD_UNUSED6, 8'h5A, 1'b0);
        send_item(CMD_UNUSED7, 8'hA5, 1'b1);
        send_item(CMD_LOCK, 8'hFF, 1'b0);        // free: plain acquire
        send_item(CMD_INIT, 8'h00, 1'b1);
        send_item(CMD_DESTROY, 8'h00, 1'b1);
    endtask

    task automatic test_recursive();
        wait_drained();
        configure(KIND_RECURSIVE, 2'b00);
        send_item(CMD_LOCK, 8'hA5, 1'b1);
        send_item(CMD_TRYLOCK, 8'hA5, 1'b1);     // count 2
        send_item(CMD_LOCK, 8'h5A, 1'b1);        // other caller: busy
        send_item(CMD_UNLOCK, 8'h5A, 1'b1);
        send_item(CMD_UNLOCK, 8'hA5, 1'b1);      // count 1, no release
        send_item(CMD_UNLOCK, 8'hA5, 1'b1);      // release
    endtask

    task automatic test_errorcheck();
        wait_drained();
        configure(KIND_ERRCHECK, 2'b00);
        send_item(CMD_LOCK, 8'h3C, 1'b1);
        send_item(CMD_LOCK, 8'h3C, 1'b1);        // self relock: deadlock
        send_item(CMD_TRYLOCK, 8'h3C, 1'b0);
        send_item(CMD_TRYLOCK, 8'hC3, 1'b1);
        send_item(CMD_UNLOCK, 8'h3C, 1'b1);
        send_item(CMD_UNLOCK, 8'h3C, 1'b1);
    endtask

    // Kind code 3 falls back to normal; robust bit taken from wdata bit 0 only
    task automatic test_spare_kind();
        wait_drained();
        configure(KIND_SPARE, 2'b10);
        send_item(CMD_LOCK, 8'h01, 1'b1);
        send_item(CMD_LOCK, 8'h01, 1'b1);
        send_item(CMD_LOCK, 8'h02, 1'b0);
        send_item(CMD_UNLOCK, 8'h01, 1'b1);
    endtask

    task automatic test_robust_takeover();
        wait_drained();
        configure(KIND_RECURSIVE, 2'b01);
        send_item(CMD_INIT, 8'h00, 1'b1);
        send_item(CMD_LOCK, 8'h11, 1'b1);
        send_item(CMD_LOCK, 8'h22, 1'b1);        // owner alive: busy
        send_item(CMD_LOCK, 8'h22, 1'b0);        // takeover, inconsistent
        send_item(CMD_TRYLOCK, 8'h11, 1'b0);     // trylock never takes over
        send_item(CMD_CONSISTENT, 8'h11, 1'b1);  // not the owner
        send_item(CMD_CONSISTENT, 8'h22, 1'b1);
        send_item(CMD_CONSISTENT, 8'h22, 1'b1);  // already consistent
        send_item(CMD_LOCK, 8'h33, 1'b0);
        send_item(CMD_UNLOCK, 8'h33, 1'b1);      // inconsistent unlock: unusable
        send_item(CMD_TRYLOCK, 8'h33, 1'b1);
        send_item(CMD_LOCK, 8'h44, 1'b0);
        send_item(CMD_DESTROY, 8'h44, 1'b1);
        send_item(CMD_INIT, 8'h44, 1'b0);
        send_item(CMD_LOCK, 8'h44, 1'b0);        // no owner recorded after init
    endtask

    // Drive the recursive count to its top, then retry, then take over from there
    task automatic test_count_saturation();
        wait_drained();
        configure(KIND_RECURSIVE, 2'b11);
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        send_item(CMD_INIT, 8'h80, 1'b1);
        for (int n = 0; n < (1 << HOLD_W) - 1; n++)
            send_item((n % 2 == 0) ? CMD_LOCK : CMD_TRYLOCK, 8'h80, 1'b1);
        send_item(CMD_LOCK, 8'h80, 1'b1);
        send_item(CMD_TRYLOCK, 8'h80, 1'b0);
        send_item(CMD_UNLOCK, 8'h80, 1'b1);
        send_item(CMD_TRYLOCK, 8'h80, 1'b1);     // back at the top
        send_item(CMD_LOCK, 8'h7F, 1'b0);        // takeover drops count to one
        send_item(CMD_INIT, 8'h7F, 1'b1);
    endtask

    // Mostly well-formed lock/unlock traffic among a few threads, some noise
    task automatic test_random_traffic();
        t_kind             kinds   [RANDOM_PHASES];
        logic              robusts [RANDOM_PHASES];
        logic [ID_W-1:0]   pool    [4];
        t_cmd              c;
        logic [ID_W-1:0]   id;
        logic              alive;
        int                r;
        kinds   = '{KIND_NORMAL, KIND_RECURSIVE, KIND_ERRCHECK, KIND_SPARE,
                    KIND_RECURSIVE, KIND_NORMAL, KIND_ERRCHECK, KIND_RECURSIVE};
        robusts = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            configure(kinds[p], {1'($urandom_range(0, 1)), robusts[p]});
            // one phase with no idling on either side
            tx_gap_pct   = (p == 3) ? 0 : $urandom_range(5, 40);
            rx_stall_pct = (p == 3) ? 0 : $urandom_range(5, 50);
            foreach (pool[k])
                pool[k] = ID_W'($urandom_range(0, 255));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && p % 2 == 0)
                    wait_drained();   // sender holds off until all results are back
                r     = $urandom_range(0, 99);
                id    = pool[$urandom_range(0, 3)];
                alive = ($urandom_range(0, 3) != 0);
                if (r < 8) begin
                    c     = t_cmd'($urandom_range(0, 7));
                    id    = ID_W'($urandom_range(0, 255));
                    alive = 1'($urandom_range(0, 1));
                end else if (r < 40) begin
                    c = CMD_LOCK;
                end else if (r < 58) begin
                    c = CMD_TRYLOCK;
                end else if (r < 86) begin
                    c = CMD_UNLOCK;
                end else if (r < 94) begin
                    c = CMD_CONSISTENT;
                end else if (r < 97) begin
                    c = CMD_DESTROY;
                end else begin
                    c = CMD_INIT;
                end
                // unlock and repair are mostly issued by the owner
                if ((c == CMD_UNLOCK || c == CMD_CONSISTENT) && r >= 8
                    && $urandom_range(0, 9) < 7)
                    id = mx_owner;
                send_item(c, id, alive);
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_normal_after_reset();
        test_recursive();
        test_errorcheck();
        test_spare_kind();
        test_robust_takeover();
        test_count_saturation();
        test_random_traffic();
        wait_drained();
        if (errors == 0)
            $display("PASS robust_recursive_mutex_unit");
        else
            $display("FAIL robust_recursive_mutex_unit");
        $finish;
    end

endmodule
